[sv/pidaw_pkg.sv]
// ----------------------------------------------------------------------------
// pidaw_pkg
// Types and constants shared by the PID controller with clamping anti-windup.
// ----------------------------------------------------------------------------
package pidaw_pkg;

	typedef enum logic {
		CMD_UPDATE = 1'b0,
		CMD_CLEAR  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		SAT_NONE = 2'd0,
		SAT_HIGH = 2'd1,
		SAT_LOW  = 2'd2
	} sat_t;

	typedef enum logic [1:0] {
		REG_GAIN_P = 2'd0,
		REG_GAIN_I = 2'd1,
		REG_GAIN_D = 2'd2,
		REG_LIMIT  = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_MUL,
		B_SUM,
		B_OUT
	} bstate_t;

	// classified word handed from front to back
	typedef struct packed {
		cmd_t               cmd;
		logic signed [32:0] err;
		logic signed [32:0] deriv;
	} item_t;

	localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

	localparam logic signed [31:0] GAIN_P_RST = 32'sd1;
	localparam logic signed [31:0] GAIN_I_RST = 32'sd0;
	localparam logic signed [31:0] GAIN_D_RST = 32'sd0;
	localparam logic [30:0]        LIMIT_RST  = 31'd1000;

endpackage

[sv/pidaw_fifo.sv]
// ----------------------------------------------------------------------------
// pidaw_fifo
// Small queue decoupling the front classifier from the back datapath.
// ----------------------------------------------------------------------------
module pidaw_fifo
	import pidaw_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  in_ready,
	input  logic  pop,
	output item_t pop_item,
	output logic  out_valid
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t         mem_q [DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign in_ready  = (count_q != CW'(DEPTH));
	assign out_valid = (count_q != '0);
	assign pop_item  = mem_q[rptr_q];
	assign do_push   = push && in_ready;
	assign do_pop    = pop && out_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[sv/pidaw_front.sv]
// ----------------------------------------------------------------------------
// pidaw_front
// Accepts input words, forms error and measurement derivative, tracks the
// stored sensor value and queues the classified word.
// ----------------------------------------------------------------------------
module pidaw_front
	import pidaw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_cmd,
	input  logic [63:0] in_data,
	input  logic        q_ready,
	output logic        push,
	output item_t       push_item
);

	logic signed [31:0] prev_sensor_q;
	logic signed [31:0] reference;
	logic signed [31:0] sensor;
	cmd_t               cmd;

	assign reference = $signed(in_data[31:0]);
	assign sensor    = $signed(in_data[63:32]);
	assign cmd       = cmd_t'(in_cmd);
	assign push      = in_valid && q_ready;

	always_comb begin
		push_item.cmd   = cmd;
		push_item.err   = 33'(reference) - 33'(sensor);
		push_item.deriv = 33'(prev_sensor_q) - 33'(sensor);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sensor_q <= '0;
		end else if (push) begin
			prev_sensor_q <= (cmd == CMD_CLEAR) ? '0 : sensor;
		end
	end

endmodule

[sv/pidaw_back.sv]
// ----------------------------------------------------------------------------
// pidaw_back
// Integrator loop: saturating integrate, three gain products, wide sum,
// clamp with anti-windup, and the output register.
// ----------------------------------------------------------------------------
module pidaw_back
	import pidaw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata
);

	bstate_t state_q;
	bstate_t state_d;

	logic signed [31:0] gain_p_q;
	logic signed [31:0] gain_i_q;
	logic signed [31:0] gain_d_q;
	logic [30:0]        limit_q;

	logic signed [31:0] integ_q;
	logic signed [31:0] new_int_s1;
	logic signed [32:0] err_s1;
	logic signed [32:0] deriv_s1;
	logic signed [64:0] prod_p_s2;
	logic signed [64:0] prod_i_s2;
	logic signed [64:0] prod_d_s2;
	logic signed [66:0] sum_s3;

	logic               out_valid_q;
	logic signed [31:0] control_q;
	logic signed [32:0] error_q;
	sat_t               sat_q;

	logic               out_free;
	logic               int_clear;
	logic               take;
	logic               out_load;
	logic signed [33:0] int_sum;
	logic signed [31:0] int_sat;
	logic signed [66:0] lim_pos;
	logic signed [66:0] lim_neg;
	logic               clamp_high;
	logic               clamp_low;

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (q_valid && q_item.cmd == CMD_UPDATE) begin
					state_d = B_MUL;
				end
			end
			B_MUL: state_d = B_SUM;
			B_SUM: state_d = B_OUT;
			B_OUT: begin
				if (out_free) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		int_clear = 1'b0;
		take      = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				pop       = q_valid;
				int_clear = q_valid && q_item.cmd == CMD_CLEAR;
				take      = q_valid && q_item.cmd == CMD_UPDATE;
			end
			B_OUT:   out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= GAIN_P_RST;
			gain_i_q <= GAIN_I_RST;
			gain_d_q <= GAIN_D_RST;
			limit_q  <= LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_GAIN_P: gain_p_q <= $signed(cfg_data);
				REG_GAIN_I: gain_i_q <= $signed(cfg_data);
				REG_GAIN_D: gain_d_q <= $signed(cfg_data);
				REG_LIMIT:  limit_q  <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// saturating integrate
	always_comb begin
		int_sum = 34'(integ_q) + 34'(q_item.err);
		if (int_sum > 34'(INT_MAX)) begin
			int_sat = INT_MAX;
		end else if (int_sum < 34'(INT_MIN)) begin
			int_sat = INT_MIN;
		end else begin
			int_sat = int_sum[31:0];
		end
	end

	assign lim_pos    = $signed(67'(limit_q));
	assign lim_neg    = -lim_pos;
	assign clamp_high = sum_s3 > lim_pos;
	assign clamp_low  = sum_s3 < lim_neg;

	always_ff @(posedge clk) begin
		if (take) begin
			new_int_s1 <= int_sat;
			err_s1     <= q_item.err;
			deriv_s1   <= q_item.deriv;
		end
		if (state_q == B_MUL) begin
			prod_p_s2 <= 65'(gain_p_q) * 65'(err_s1);
			prod_i_s2 <= 65'(gain_i_q) * 65'(new_int_s1);
			prod_d_s2 <= 65'(gain_d_q) * 65'(deriv_s1);
		end
		if (state_q == B_SUM) begin
			sum_s3 <= 67'(prod_p_s2) + 67'(prod_i_s2) + 67'(prod_d_s2);
		end
		if (out_load) begin
			error_q <= err_s1;
			if (clamp_high) begin
				control_q <= $signed({1'b0, limit_q});
				sat_q     <= SAT_HIGH;
			end else if (clamp_low) begin
				control_q <= lim_neg[31:0];
				sat_q     <= SAT_LOW;
			end else begin
				control_q <= sum_s3[31:0];
				sat_q     <= SAT_NONE;
			end
		end
	end

	// integrator holds its old value when the output clamps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (int_clear) begin
				integ_q <= '0;
			end else if (out_load && !clamp_high && !clamp_low) begin
				integ_q <= new_int_s1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, sat_q, error_q, control_q};

endmodule

[sv/pid_controller_antiwindup.sv]
// ----------------------------------------------------------------------------
// pid_controller_antiwindup
// Integer PID step with clamping anti-windup on a streaming interface.
// ----------------------------------------------------------------------------
// Input words arrive on s_t*: s_tuser is the command (0 update, 1 clear),
// s_tdata holds reference and sensor. Each update gives one output word on
// m_t* with the clamped drive, the error and the clamp flag; a clear word
// zeroes the integrator and the stored sensor and gives no output.
// Gains and the output limit are to be written on the cfg_* channel only
// while idle; the block itself does not enforce this. While the queue
// has room, the front takes one word per cycle into a queue of
// QUEUE_DEPTH words. The back steps each update through integrate,
// multiply, sum and clamp; the integrator of one update is known only
// after its clamp, so a new update is taken only after the last is output.
// If the receiver stalls, the result waits in the output register, the
// back holds the next finished result, and the queue fills before
// s_tready drops. Reset clears the state, the queue and the output and
// loads gain_p 1, gain_i 0, gain_d 0, limit 1000.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup
	import pidaw_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // reference[31:0], sensor[63:32]
	input  logic        s_tuser,   // command[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // control_out[31:0], error_out[64:32],
	                               // saturated[66:65], zero[71:67]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic  q_ready;
	logic  q_push;
	item_t q_push_item;
	logic  q_pop;
	item_t q_pop_item;
	logic  q_valid;

	assign s_tready  = q_ready;
	assign cfg_ready = 1'b1;

	pidaw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_cmd    (s_tuser),
		.in_data   (s_tdata),
		.q_ready   (q_ready),
		.push      (q_push),
		.push_item (q_push_item)
	);

	pidaw_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.in_ready  (q_ready),
		.pop       (q_pop),
		.pop_item  (q_pop_item),
		.out_valid (q_valid)
	);

	pidaw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_item    (q_pop_item),
		.pop       (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

[test/pid_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_checker
// Watches the input, output and register channels of the PID controller,
// predicts every output word from its own copy of gains, integrator and
// stored sensor, and compares the words field by field in order.
// ----------------------------------------------------------------------------
module pid_checker
	import pidaw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,   // reference[31:0], sensor[63:32]
	input  logic        s_tuser,   // command[0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,   // control_out[31:0], error_out[64:32],
	                               // saturated[66:65], zero[71:67]
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          outstanding,
	output int          n_updates,
	output int          n_clears,
	output int          n_clamped,
	output int          n_int_sat
);

	typedef struct packed {
		logic signed [31:0] control;
		logic signed [32:0] error;
		sat_t               sat;
	} drive_word_t;

	drive_word_t drive_expect_q[$];

	logic signed [31:0] p_gain = GAIN_P_RST;
	logic signed [31:0] i_gain = GAIN_I_RST;
	logic signed [31:0] d_gain = GAIN_D_RST;
	logic [30:0]        o_limit = LIMIT_RST;
	logic signed [31:0] integ = '0;
	logic signed [31:0] last_sensor = '0;

	int fails = 0;
	int updates = 0;
	int clears = 0;
	int clamps = 0;
	int int_sats = 0;

	// one control step; updates integrator and stored sensor
	function automatic drive_word_t pid_predict(logic signed [31:0] target,
	                                            logic signed [31:0] meas_v);
		logic signed [32:0] err;
		logic signed [32:0] deriv;
		logic signed [33:0] sum;
		logic signed [31:0] held;
		logic signed [95:0] gp_w, gi_w, gd_w, e_w, h_w, d_w, u, lim;
		drive_word_t w;
		err   = $signed({target[31], target}) - $signed({meas_v[31], meas_v});
		deriv = $signed({last_sensor[31], last_sensor}) - $signed({meas_v[31], meas_v});
		sum   = $signed({{2{integ[31]}}, integ}) + $signed({err[32], err});
		if (sum > 34'sd2147483647) begin
			held = INT_MAX;
			int_sats++;
		end else if (sum < -34'sd2147483648) begin
			held = INT_MIN;
			int_sats++;
		end else begin
			held = sum[31:0];
		end
		gp_w = p_gain;
		gi_w = i_gain;
		gd_w = d_gain;
		e_w  = err;
		h_w  = held;
		d_w  = deriv;
		u    = gp_w * e_w + gi_w * h_w + gd_w * d_w;
		lim  = $signed({65'd0, o_limit});
		w.error = err;
		if (u > lim) begin
			w.control = {1'b0, o_limit};
			w.sat     = SAT_HIGH;
			clamps++;
		end else if (u < -lim) begin
			w.control = -$signed({1'b0, o_limit});
			w.sat     = SAT_LOW;
			clamps++;
		end else begin
			w.control = u[31:0];
			w.sat     = SAT_NONE;
			integ     = held;
		end
		last_sensor = meas_v;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		drive_word_t got;
		drive_word_t want;
		if (!arst_n) begin
			p_gain      = GAIN_P_RST;
			i_gain      = GAIN_I_RST;
			d_gain      = GAIN_D_RST;
			o_limit     = LIMIT_RST;
			integ       = '0;
			last_sensor = '0;
			drive_expect_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_GAIN_P: p_gain = cfg_data;
					REG_GAIN_I: i_gain = cfg_data;
					REG_GAIN_D: d_gain = cfg_data;
					REG_LIMIT:  o_limit = cfg_data[30:0];
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.control = m_tdata[31:0];
				got.error   = m_tdata[64:32];
				got.sat     = sat_t'(m_tdata[66:65]);
				if (drive_expect_q.size() == 0) begin
					fails++;
					$display("%0t: unexpected word, expected none, actual %h", $time, m_tdata);
				end else begin
					want = drive_expect_q.pop_front();
					if (got.control !== want.control) begin
						fails++;
						$display("%0t: control_out expected %0d actual %0d",
						         $time, want.control, got.control);
					end
					if (got.error !== want.error) begin
						fails++;
						$display("%0t: error_out expected %0d actual %0d",
						         $time, want.error, got.error);
					end
					if (got.sat !== want.sat) begin
						fails++;
						$display("%0t: saturated expected %0d actual %0d",
						         $time, want.sat, m_tdata[66:65]);
					end
					if (m_tdata[71:67] !== 5'd0) begin
						fails++;
						$display("%0t: pad bits expected 0 actual %b", $time, m_tdata[71:67]);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (cmd_t'(s_tuser) == CMD_CLEAR) begin
					integ       = '0;
					last_sensor = '0;
					clears++;
				end else begin
					drive_expect_q.push_back(pid_predict(s_tdata[31:0], s_tdata[63:32]));
					updates++;
				end
			end
		end
		fail_count  <= fails;
		outstanding <= drive_expect_q.size();
		n_updates   <= updates;
		n_clears    <= clears;
		n_clamped   <= clamps;
		n_int_sat   <= int_sats;
	end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the PID controller with clamping anti-windup:
// directed edge cases, then random setpoint/measurement runs over many gain
// and limit settings, with random stalls on both stream sides in all but the last mode.
// ----------------------------------------------------------------------------
module tb_top;
	import pidaw_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;   // reference[31:0], sensor[63:32]
	logic        s_tuser = 1'b0; // command[0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;        // control_out[31:0], error_out[64:32],
	                             // saturated[66:65], zero[71:67]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	int fail_count, outstanding, n_updates, n_clears, n_clamped, n_int_sat;
	int idle_s = 31;
	int idle_r = 75;
	int n_writes = 0;

	logic [31:0] setpoint = '0;
	logic [31:0] meas = '0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= idle_r);
	end

	pid_controller_antiwindup uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pid_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.n_updates   (n_updates),
		.n_clears    (n_clears),
		.n_clamped   (n_clamped),
		.n_int_sat   (n_int_sat)
	);

	task automatic push_sample(cmd_t c, logic [31:0] target, logic [31:0] sensed);
		while ($urandom_range(99) < idle_s) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c;
		s_tdata  <= {sensed, target};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// wait for every pending word, then let a clear word finish
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		n_writes++;
	endtask

	task automatic load_regs(logic [31:0] gp, logic [31:0] gi, logic [31:0] gd,
	                         logic [31:0] lim);
		drain();
		write_reg(REG_GAIN_P, gp);
		write_reg(REG_GAIN_I, gi);
		write_reg(REG_GAIN_D, gd);
		write_reg(REG_LIMIT, lim);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_val();
		logic [31:0] v;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: v = $urandom_range(4000) - 2000;
			5, 6:          v = $urandom;
			7:             v = $urandom_range(32'h20_0000) - 32'h10_0000;
			default: begin
				case ($urandom_range(3))
					0:       v = INT_MIN;
					1:       v = INT_MAX;
					2:       v = '0;
					default: v = '1;
				endcase
			end
		endcase
		return v;
	endfunction

	function automatic logic [31:0] rand_gain();
		logic [31:0] g;
		case ($urandom_range(5))
			0:       g = $urandom;
			1:       g = ($urandom_range(1) != 0) ? INT_MIN : INT_MAX;
			default: g = $urandom_range(16) - 8;
		endcase
		return g;
	endfunction

	function automatic logic [31:0] rand_limit();
		logic [31:0] l;
		case ($urandom_range(6))
			0:       l = '0;
			1:       l = '1;
			2:       l = $urandom;
			default: l = $urandom_range(5000);
		endcase
		return l;
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset gains: proportional only, limit 1000
		push_sample(CMD_UPDATE, 32'd0, 32'd0);
		push_sample(CMD_UPDATE, 32'd500, 32'd0);
		push_sample(CMD_UPDATE, 32'd2000, 32'd0);
		push_sample(CMD_UPDATE, -32'sd2000, 32'd0);
		push_sample(CMD_UPDATE, INT_MAX, INT_MIN);
		push_sample(CMD_UPDATE, INT_MIN, INT_MAX);
		push_sample(CMD_CLEAR, INT_MIN, INT_MAX);

		// integral only, widest limit: drive the integrator into its high rail, then clamp the output low
		load_regs(32'd0, 32'd1, 32'd0, {1'b0, {31{1'b1}}});
		push_sample(CMD_UPDATE, INT_MAX, INT_MIN);
		push_sample(CMD_UPDATE, INT_MAX, INT_MIN);
		push_sample(CMD_UPDATE, INT_MIN, INT_MAX);
		push_sample(CMD_UPDATE, INT_MIN, INT_MAX);
		push_sample(CMD_UPDATE, INT_MIN, INT_MAX);
		push_sample(CMD_CLEAR, 32'd0, 32'd0);

		// extreme gains, limit written with bit 31 set
		load_regs(INT_MIN, INT_MAX, INT_MIN, '1);
		push_sample(CMD_UPDATE, INT_MAX, INT_MIN);
		push_sample(CMD_UPDATE, '1, 32'd0);
		push_sample(CMD_UPDATE, 32'd0, INT_MAX);

		// zero limit
		load_regs(32'd1, 32'd0, '1, 32'd0);
		push_sample(CMD_CLEAR, '1, '1);
		push_sample(CMD_UPDATE, 32'd0, 32'd0);
		push_sample(CMD_UPDATE, 32'd5, 32'd0);
		push_sample(CMD_UPDATE, -32'sd5, 32'd0);

		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin idle_s = 31; idle_r = 75; end
				1: begin idle_s = 75; idle_r = 31; end
				default: begin idle_s = 0; idle_r = 0; end
			endcase
			for (int grp = 0; grp < 6; grp++) begin
				load_regs(rand_gain(), rand_gain(), rand_gain(), rand_limit());
				for (int k = 0; k < 50; k++) begin
					if ($urandom_range(24) == 0) begin
						push_sample(CMD_CLEAR, $urandom, $urandom);
					end else begin
						if ($urandom_range(3) == 0)
							setpoint = rand_val();
						if ($urandom_range(2) == 0)
							meas = rand_val();
						else
							meas = meas + $urandom_range(200) - 100;
						push_sample(CMD_UPDATE, setpoint, meas);
					end
				end
			end
		end

		drain();
		$display("Covered %0d updates and %0d clears over %0d register writes,",
		         n_updates, n_clears, n_writes);
		$display("with %0d clamped outputs and %0d integrator saturations.",
		         n_clamped, n_int_sat);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("Timeout with %0d words outstanding", outstanding);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
